>>> sv/lz_rle_mirror_decompressor_assert.svh
// Assertion macros shared by the checker of the LZ/RLE mirror decompressor.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LZ_RLE_MIRROR_DECOMPRESSOR_ASSERT_SVH
`define LZ_RLE_MIRROR_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LZRM_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lzrm_pkg.sv
// Package for the LZ/RLE mirror decompressor: sequencer and parse types,
// command-field constants and the packer command struct. No dependencies.
`timescale 1ns / 1ps

package lzrm_pkg;

  // Width of the signed back distance; covers -2 up to 4095 - 2 + 2 * 265.
  localparam int BACK_W = 14;

  localparam logic [15:0] CMD_LITFILL_MASK = 16'h8800;
  localparam logic [2:0]  LFIELD_LITERAL   = 3'd0;
  localparam logic [2:0]  LFIELD_EXTRA     = 3'd7;
  localparam logic [8:0]  LEN_MIN          = 9'd3;
  localparam logic [8:0]  LEN_EXTRA_BASE   = 9'd10;
  localparam logic [3:0]  ACC_FULL         = 4'd8;
  localparam logic signed [BACK_W-1:0] MIRROR_STEP = BACK_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FLUSH,
    ST_FINAL
  } seq_state_t;

  typedef enum logic [2:0] {
    PH_HIGH,
    PH_LOW,
    PH_EXTRA,
    PH_LITERAL,
    PH_ENDED
  } phase_t;

  typedef struct packed {
    logic       append;
    logic       push;
    logic       last;
    logic       bad;
    logic [7:0] data;
  } pk_cmd_t;

  // First back distance of a copy; a mirrored copy starts two bytes closer.
  function automatic logic signed [BACK_W-1:0] start_back(input logic mirror,
                                                          input logic [11:0] distance);
    logic signed [BACK_W-1:0] d;
    d = $signed({{(BACK_W-12){1'b0}}, distance});
    return mirror ? d - MIRROR_STEP : d;
  endfunction

endpackage

>>> sv/lzrm_hist_ram.sv
// History window memory: one write port and one registered read port.
// Standalone; the depth comes from the top level's window parameter.
`timescale 1ns / 1ps

module lzrm_hist_ram #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/lzrm_packer.sv
// Gathers decompressed bytes eight to a result and holds the output register.
// Depends on lzrm_pkg for the command struct.
`timescale 1ns / 1ps

module lzrm_packer (
  input  logic             clk,
  input  logic             rst,
  input  lzrm_pkg::pk_cmd_t cmd,
  output logic [3:0]       acc_count,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      out_bytes,
  output logic [3:0]       out_count,
  output logic             stream_end,
  output logic             bad_reference
);

  logic [63:0] acc_bytes;
  logic [3:0]  acc_n;
  logic        acc_bad;

  assign acc_count = acc_n;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_bytes <= '0;
      acc_n     <= '0;
      acc_bad   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        out_valid <= 1'b1;
        acc_bytes <= '0;
        acc_n     <= '0;
        acc_bad   <= 1'b0;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        // The sequencer never appends to a full accumulator.
        if (cmd.append) begin
          acc_bytes[{acc_n[2:0], 3'b000} +: 8] <= cmd.data;
          acc_n   <= acc_n + 4'd1;
          acc_bad <= acc_bad | cmd.bad;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_bytes     <= acc_bytes;
      out_count     <= acc_n;
      stream_end    <= cmd.last;
      bad_reference <= acc_bad;
    end
  end

endmodule

>>> sv/lz_rle_mirror_decompressor.sv
// Top level of the LZ/RLE mirror decompressor; depends on lzrm_pkg,
// lzrm_hist_ram and lzrm_packer.
//
// The block takes one compressed byte per input transaction and returns up to
// eight decompressed bytes per output transaction, first byte in bits 7..0.
// Command bytes are parsed in the idle state; an empty literal run passes
// through the final state before input is taken again. A literal byte is
// written and then handed on as a result. In a back-reference every byte
// goes through the single history read port and the shared distance check
// before it is written back; a fill reads once and then repeats the byte.
// A result waits while the output register is full and out_ready is low.
// Input is not accepted until the current command is finished. The history
// window needs no clearing after reset: references to bytes not yet produced
// are caught by the distance check, read as zero and flag bad_reference.
`timescale 1ns / 1ps

module lz_rle_mirror_decompressor #(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic        stream_end,
  output logic        bad_reference
);

  localparam int ADDR_W = $clog2(WINDOW_BYTES);
  localparam int BW     = lzrm_pkg::BACK_W;

  lzrm_pkg::seq_state_t state, state_next;
  lzrm_pkg::phase_t     phase, phase_next;

  logic [15:0]          cmd_word, cmd_word_next;
  logic [10:0]          lit_rem, lit_rem_next;
  logic [24:0]          produced, produced_next;
  logic [23:0]          out_size;
  logic [8:0]           remaining, remaining_next;
  logic signed [BW-1:0] back, back_next;
  logic                 mirror, mirror_next;
  logic                 fill, fill_next;
  logic                 use_mem, use_mem_next;
  logic                 bad_q, bad_q_next;
  logic                 step_done, step_done_next;
  logic [7:0]           hold_byte, hold_byte_next;

  logic [15:0]          cmd_full;
  logic [2:0]           lfield;
  logic                 is_litfill;
  logic [BW-2:0]        back_u;
  logic                 back_ok;
  logic [ADDR_W-1:0]    rd_addr;
  logic [7:0]           rd_data;
  logic                 wr_en;
  logic [7:0]           wr_byte;
  logic                 end_hit;
  lzrm_pkg::seq_state_t cont_state;

  lzrm_pkg::pk_cmd_t    pk_cmd;
  logic [3:0]           acc_count;
  logic                 out_free;

  lzrm_hist_ram #(
    .DEPTH(WINDOW_BYTES)
  ) u_hist_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(produced[ADDR_W-1:0]),
    .wr_data(wr_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lzrm_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .cmd          (pk_cmd),
    .acc_count    (acc_count),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bytes    (out_bytes),
    .out_count    (out_count),
    .stream_end   (stream_end),
    .bad_reference(bad_reference)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_size <= '0;
    end else if (cfg_valid) begin
      out_size <= cfg_data;
    end
  end

  // Shared reference unit: one address subtract and the window checks.
  assign cmd_full   = {cmd_word[15:8], in_byte};
  assign lfield     = cmd_full[14:12];
  assign is_litfill = (cmd_full & lzrm_pkg::CMD_LITFILL_MASK) == lzrm_pkg::CMD_LITFILL_MASK;
  assign back_u     = back[BW-2:0];
  assign back_ok    = !back[BW-1] && (back != '0) &&
                      ({1'b0, back_u} <= BW'(WINDOW_BYTES)) &&
                      (25'(back_u) <= produced);
  assign rd_addr    = produced[ADDR_W-1:0] - back[ADDR_W-1:0];
  assign wr_byte    = use_mem ? (bad_q ? 8'h00 : rd_data) : hold_byte;
  assign end_hit    = step_done && (produced >= {1'b0, out_size});
  assign cont_state = fill ? lzrm_pkg::ST_WRITE : lzrm_pkg::ST_READ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lzrm_pkg::ST_IDLE;
      phase     <= lzrm_pkg::PH_HIGH;
      cmd_word  <= '0;
      lit_rem   <= '0;
      produced  <= '0;
      remaining <= '0;
      step_done <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      cmd_word  <= cmd_word_next;
      lit_rem   <= lit_rem_next;
      produced  <= produced_next;
      remaining <= remaining_next;
      step_done <= step_done_next;
    end
  end

  always_ff @(posedge clk) begin
    back      <= back_next;
    mirror    <= mirror_next;
    fill      <= fill_next;
    use_mem   <= use_mem_next;
    bad_q     <= bad_q_next;
    hold_byte <= hold_byte_next;
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    cmd_word_next  = cmd_word;
    lit_rem_next   = lit_rem;
    produced_next  = produced;
    remaining_next = remaining;
    step_done_next = step_done;
    back_next      = back;
    mirror_next    = mirror;
    fill_next      = fill;
    use_mem_next   = use_mem;
    bad_q_next     = bad_q;
    hold_byte_next = hold_byte;
    in_ready       = (state == lzrm_pkg::ST_IDLE);
    wr_en          = 1'b0;
    pk_cmd         = '0;

    unique case (state)
      lzrm_pkg::ST_IDLE: begin
        if (in_valid) begin
          step_done_next = 1'b0;
          unique case (phase)
            lzrm_pkg::PH_HIGH: begin
              cmd_word_next = {in_byte, 8'h00};
              phase_next    = lzrm_pkg::PH_LOW;
            end
            lzrm_pkg::PH_LOW: begin
              cmd_word_next = cmd_full;
              if (!is_litfill) begin
                mirror_next  = cmd_full[15];
                back_next    = lzrm_pkg::start_back(cmd_full[15], cmd_full[11:0]);
                fill_next    = 1'b0;
                use_mem_next = 1'b1;
                if (lfield == lzrm_pkg::LFIELD_EXTRA) begin
                  phase_next = lzrm_pkg::PH_EXTRA;
                end else begin
                  remaining_next = lzrm_pkg::LEN_MIN + 9'(lfield);
                  step_done_next = 1'b1;
                  state_next     = lzrm_pkg::ST_READ;
                end
              end else if (lfield == lzrm_pkg::LFIELD_LITERAL) begin
                lit_rem_next = cmd_full[10:0];
                if (cmd_full[10:0] == 11'd0) begin
                  step_done_next = 1'b1;
                  state_next     = lzrm_pkg::ST_FINAL;
                end else begin
                  phase_next = lzrm_pkg::PH_LITERAL;
                end
              end else begin
                // Fill: distance is bits 10..8 over the three length bits.
                mirror_next    = 1'b0;
                fill_next      = 1'b1;
                use_mem_next   = 1'b1;
                back_next      = $signed({{(BW-6){1'b0}}, cmd_full[10:8], lfield});
                remaining_next = 9'(cmd_full[7:0]) + lzrm_pkg::LEN_MIN;
                step_done_next = 1'b1;
                state_next     = lzrm_pkg::ST_READ;
              end
            end
            lzrm_pkg::PH_EXTRA: begin
              remaining_next = lzrm_pkg::LEN_EXTRA_BASE + 9'(in_byte);
              step_done_next = 1'b1;
              state_next     = lzrm_pkg::ST_READ;
            end
            lzrm_pkg::PH_LITERAL: begin
              hold_byte_next = in_byte;
              use_mem_next   = 1'b0;
              bad_q_next     = 1'b0;
              fill_next      = 1'b0;
              mirror_next    = 1'b0;
              remaining_next = 9'd1;
              lit_rem_next   = lit_rem - 11'd1;
              step_done_next = (lit_rem == 11'd1);
              state_next     = lzrm_pkg::ST_WRITE;
            end
            lzrm_pkg::PH_ENDED: begin
            end
            default: begin
            end
          endcase
        end
      end
      lzrm_pkg::ST_READ: begin
        bad_q_next = !back_ok;
        state_next = lzrm_pkg::ST_WRITE;
      end
      lzrm_pkg::ST_WRITE: begin
        wr_en          = 1'b1;
        produced_next  = produced + 25'd1;
        pk_cmd.append  = 1'b1;
        pk_cmd.data    = wr_byte;
        pk_cmd.bad     = bad_q;
        hold_byte_next = wr_byte;
        remaining_next = remaining - 9'd1;
        // A fill reads its source once and then repeats the held byte.
        if (fill) begin
          use_mem_next = 1'b0;
        end
        if (mirror) begin
          back_next = back + lzrm_pkg::MIRROR_STEP;
        end
        if (remaining == 9'd1) begin
          state_next = lzrm_pkg::ST_FINAL;
        end else if (acc_count == lzrm_pkg::ACC_FULL - 4'd1) begin
          state_next = lzrm_pkg::ST_FLUSH;
        end else begin
          state_next = cont_state;
        end
      end
      lzrm_pkg::ST_FLUSH: begin
        if (out_free) begin
          pk_cmd.push = 1'b1;
          state_next  = cont_state;
        end
      end
      lzrm_pkg::ST_FINAL: begin
        if (acc_count == 4'd0 && !end_hit) begin
          state_next = lzrm_pkg::ST_IDLE;
          if (step_done) begin
            phase_next = lzrm_pkg::PH_HIGH;
          end
        end else if (out_free) begin
          // An ending command with no bytes still sends one empty result.
          pk_cmd.push = 1'b1;
          pk_cmd.last = end_hit;
          state_next  = lzrm_pkg::ST_IDLE;
          if (step_done) begin
            phase_next = end_hit ? lzrm_pkg::PH_ENDED : lzrm_pkg::PH_HIGH;
          end
        end
      end
      default: begin
        state_next = lzrm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/lzrm_checker.sv
// Port-level checker for the LZ/RLE mirror decompressor, bound to the top.
// Depends on lz_rle_mirror_decompressor_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`include "lz_rle_mirror_decompressor_assert.svh"

module lzrm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bytes,
  input logic [3:0]  out_count,
  input logic        stream_end,
  input logic        bad_reference
);

  `LZRM_ASSERT_HOLDS(a_count_range, out_valid, out_count <= 4'd8, "out_count above eight")
  `LZRM_ASSERT_HOLDS(a_empty_only_at_end, out_valid && out_count == 4'd0, stream_end && out_bytes == 64'd0 && !bad_reference, "empty result that does not end the stream")
  `LZRM_ASSERT_NEXT(a_silent_after_end, out_valid && out_ready && stream_end, !out_valid, "result after the end of the stream")
  `LZRM_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_bytes) && $stable(out_count), "stalled result changed")

endmodule

bind lz_rle_mirror_decompressor lzrm_checker u_lzrm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_bytes    (out_bytes),
  .out_count    (out_count),
  .stream_end   (stream_end),
  .bad_reference(bad_reference)
);

>>> tb/sv/lzrm_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for lz_rle_mirror_decompressor: watches the input, configuration
// and output channels, predicts every output transaction and compares it.
// Depends on lzrm_pkg for the parse phases and command-field constants.

module lzrm_stream_checker #(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [23:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_bytes,
  input  logic [3:0]  out_count,
  input  logic        stream_end,
  input  logic        bad_reference,
  output int          pending,
  output int          mismatches,
  output int          beats_checked
);

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        bad;
  } beat_t;

  beat_t            expected_beats[$];
  logic [7:0]       window_mem[WINDOW_BYTES];
  logic [24:0]      produced;
  lzrm_pkg::phase_t phase;
  logic [15:0]      cmd;
  logic [10:0]      lit_left;
  logic [23:0]      size_limit;
  logic [63:0]      acc_data;
  logic [3:0]       acc_count;
  logic             acc_bad;
  int               step_beats;

  // A source is bad when it is not produced yet or has left the window.
  function automatic logic [7:0] fetch_back(input int back, output logic bad);
    logic [24:0] pos;
    if (back < 1 || back > WINDOW_BYTES || back > int'(produced)) begin
      bad = 1'b1;
      return 8'h00;
    end
    bad = 1'b0;
    pos = produced - 25'(back);
    return window_mem[pos % WINDOW_BYTES];
  endfunction

  task automatic close_beat();
    beat_t b;
    if (acc_count == 4'd0) return;
    b = '{data: acc_data, count: acc_count, last: 1'b0, bad: acc_bad};
    expected_beats.push_back(b);
    step_beats++;
    acc_data  = '0;
    acc_count = '0;
    acc_bad   = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] v, input logic bad);
    window_mem[produced % WINDOW_BYTES] = v;
    produced = produced + 25'd1;
    acc_data[8*acc_count +: 8] = v;
    acc_count = acc_count + 4'd1;
    if (bad) acc_bad = 1'b1;
    if (acc_count == lzrm_pkg::ACC_FULL) close_beat();
  endtask

  // Forward copies re-read the same distance, so they may overlap their own
  // output. Mirrored copies walk backwards two positions per byte.
  task automatic copy_run(input int len);
    int         distance;
    int         back;
    int         i;
    logic [7:0] v;
    logic       bad;
    distance = int'(cmd[11:0]);
    for (i = 0; i < len; i++) begin
      back = cmd[15] ? distance - 2 + 2 * i : distance;
      v = fetch_back(back, bad);
      push_byte(v, bad);
    end
  endtask

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    mismatches++;
    $error("%s: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk) begin : watch
    logic [2:0] lf;
    logic       done;
    logic       bad;
    logic [7:0] v;
    int         n;
    beat_t      tail;
    beat_t      want;
    if (rst) begin
      produced   = '0;
      phase      = lzrm_pkg::PH_HIGH;
      cmd        = '0;
      lit_left   = '0;
      size_limit = '0;
      acc_data   = '0;
      acc_count  = '0;
      acc_bad    = 1'b0;
      expected_beats.delete();
      pending       = 0;
      mismatches    = 0;
      beats_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) size_limit = cfg_data;

      if (in_valid && in_ready) begin
        done       = 1'b0;
        step_beats = 0;
        acc_data   = '0;
        acc_count  = '0;
        acc_bad    = 1'b0;
        case (phase)
          lzrm_pkg::PH_HIGH: begin
            cmd   = {in_byte, 8'h00};
            phase = lzrm_pkg::PH_LOW;
          end
          lzrm_pkg::PH_LOW: begin
            cmd[7:0] = in_byte;
            lf = cmd[14:12];
            if ((cmd & lzrm_pkg::CMD_LITFILL_MASK) != lzrm_pkg::CMD_LITFILL_MASK) begin
              if (lf == lzrm_pkg::LFIELD_EXTRA) begin
                phase = lzrm_pkg::PH_EXTRA;
              end else begin
                copy_run(int'(lf) + int'(lzrm_pkg::LEN_MIN));
                done = 1'b1;
              end
            end else if (lf == lzrm_pkg::LFIELD_LITERAL) begin
              lit_left = cmd[10:0];
              if (lit_left == 11'd0) done = 1'b1;
              else phase = lzrm_pkg::PH_LITERAL;
            end else begin
              // Fill: one read, the same byte written count + 3 times.
              v = fetch_back(int'({cmd[10:8], lf}), bad);
              n = int'(cmd[7:0]) + int'(lzrm_pkg::LEN_MIN);
              repeat (n) push_byte(v, bad);
              done = 1'b1;
            end
          end
          lzrm_pkg::PH_EXTRA: begin
            copy_run(int'(lzrm_pkg::LEN_EXTRA_BASE) + int'(in_byte));
            done = 1'b1;
          end
          lzrm_pkg::PH_LITERAL: begin
            push_byte(in_byte, 1'b0);
            lit_left = lit_left - 11'd1;
            if (lit_left == 11'd0) done = 1'b1;
          end
          default: begin
            // The stream has ended; bytes are dropped until reset.
            phase = lzrm_pkg::PH_ENDED;
          end
        endcase
        close_beat();
        if (done) begin
          if (produced >= size_limit) begin
            if (step_beats == 0) begin
              tail = '0;
              expected_beats.push_back(tail);
            end
            tail = expected_beats.pop_back();
            tail.last = 1'b1;
            expected_beats.push_back(tail);
            phase = lzrm_pkg::PH_ENDED;
          end else begin
            phase = lzrm_pkg::PH_HIGH;
          end
        end
      end

      if (out_valid && out_ready) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          mismatches++;
          $error("output transaction with nothing expected: out_bytes %h", out_bytes);
        end else begin
          want = expected_beats.pop_front();
          if (out_bytes !== want.data) report_field("out_bytes", want.data, out_bytes);
          if (out_count !== want.count) report_field("out_count", 64'(want.count), 64'(out_count));
          if (stream_end !== want.last) report_field("stream_end", 64'(want.last), 64'(stream_end));
          if (bad_reference !== want.bad)
            report_field("bad_reference", 64'(want.bad), 64'(bad_reference));
        end
      end

      pending = expected_beats.size();
    end
  end

endmodule

>>> tb/sv/lz_rle_mirror_decompressor_tb.sv
`timescale 1ns / 1ps
// Testbench top for lz_rle_mirror_decompressor: clock, reset, stimulus and verdict.
// Depends on lzrm_pkg, the block itself and lzrm_stream_checker.

module lz_rle_mirror_decompressor_tb;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = 24'h000000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;
  logic        stream_end;
  logic        bad_reference;

  int pending;
  int mismatches;
  int beats_checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ticket   = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet         = 0;
  int bytes_sent    = 0;

  logic [7:0] burst[$];

  always #4 clk = ~clk;

  lz_rle_mirror_decompressor i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bytes    (out_bytes),
    .out_count    (out_count),
    .stream_end   (stream_end),
    .bad_reference(bad_reference)
  );

  lzrm_stream_checker i_check (.*);

  // Receiver: random idling, or a long hold-off whenever a new ticket is raised.
  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic push_word(input logic [15:0] w);
    burst.push_back(w[15:8]);
    burst.push_back(w[7:0]);
  endtask

  task automatic send_burst();
    while (burst.size() != 0) send_byte(burst.pop_front());
  endtask

  // Stop offering, let every expected result arrive, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int target);
    int          start;
    int          pick;
    int          n;
    logic [15:0] w;
    logic [2:0]  lf;
    logic [11:0] distance;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(48) : $urandom_range(8, 1);
        push_word(lzrm_pkg::CMD_LITFILL_MASK | 16'(n));
        repeat (n) burst.push_back(8'($urandom));
      end else if (pick < 50) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(20);
        push_word({1'b1, 3'($urandom_range(7, 1)), 1'b1, 3'($urandom_range(7)), 8'(n)});
      end else if (pick < 92) begin
        lf       = 3'($urandom_range(7));
        distance = ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(48, 1));
        w = {1'($urandom_range(1)), lf, distance};
        // A mirrored copy must keep bit 11 clear or it decodes as a literal run or fill.
        if ((w & lzrm_pkg::CMD_LITFILL_MASK) == lzrm_pkg::CMD_LITFILL_MASK) w[11] = 1'b0;
        push_word(w);
        if (lf == lzrm_pkg::LFIELD_EXTRA)
          burst.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(24)));
      end else begin
        // Arbitrary command word; a literal run is kept short.
        w = 16'($urandom);
        if ((w & lzrm_pkg::CMD_LITFILL_MASK) == lzrm_pkg::CMD_LITFILL_MASK) begin
          if (w[14:12] == lzrm_pkg::LFIELD_LITERAL) begin
            w[10:0] = 11'($urandom_range(15));
            push_word(w);
            repeat (int'(w[10:0])) burst.push_back(8'($urandom));
          end else begin
            push_word(w);
          end
        end else begin
          push_word(w);
          if (w[14:12] == lzrm_pkg::LFIELD_EXTRA) burst.push_back(8'($urandom));
        end
      end
      send_burst();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_size(24'hFFFFFF);

    send_idle_pct = 37;
    recv_idle_pct = 54;
    // The receiver stalls at once, so the first commands back up into the block.
    hold_ticket <= hold_ticket + 1;
    push_word(16'h0000);                   // zero distance before anything is produced
    push_word(lzrm_pkg::CMD_LITFILL_MASK | 16'd4);
    push_word(16'h00FF);
    push_word(16'hA55A);
    push_word(16'h9800);                   // shortest fill at distance one
    push_word(16'h0001);                   // forward copy overlapping its own output
    push_word(16'hA003);                   // short mirrored copy
    push_word(16'hFFFF);                   // longest fill from the farthest distance
    push_word(16'h7FFF);                   // longest forward copy, far beyond the output
    burst.push_back(8'hFF);
    push_word(16'hF7FF);                   // mirrored copy with an extension byte of zero
    burst.push_back(8'h00);
    push_word(lzrm_pkg::CMD_LITFILL_MASK); // empty literal run in mid stream
    send_burst();
    wait_drained();

    write_size(24'($urandom_range(24'hFFFFFE, 24'h100000)));
    run_random(70);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 37;
    write_size(24'($urandom_range(24'hFFFFFE, 24'h100000)));
    run_random(70);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(24'($urandom_range(24'hFFFFFE, 24'h100000)));
    run_random(60);
    wait_drained();

    // A size of zero ends the stream after the next command, here an empty one.
    write_size(24'h000000);
    push_word(lzrm_pkg::CMD_LITFILL_MASK);
    send_burst();
    wait_drained();

    // Bytes after the end must be dropped without any result.
    push_word(16'($urandom));
    burst.push_back(8'($urandom));
    send_burst();
    wait_drained();

    $display("Summary: %0d compressed bytes through literal, fill and copy commands,",
             bytes_sent);
    $display("  %0d output transactions compared under three idling modes and a long stall.",
             beats_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
